// ===== hw/rtl/iol_pkg.sv =====
// Package for the indexed ordered list: field widths, default sizes
// and request codes. No dependencies.
package iol_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;

	localparam int REQ_W  = 3;
	localparam int POS_W  = 5;
	localparam int DATA_W = 32;
	localparam int LEN_W  = 5;

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND = 3'd0,
		REQ_POP    = 3'd1,
		REQ_GET    = 3'd2,
		REQ_REMOVE = 3'd3,
		REQ_INSERT = 3'd4,
		REQ_CLEAR  = 3'd5
	} req_t;

endpackage

// ===== hw/rtl/indexed_ordered_list.sv =====
// Indexed ordered list top level: word store in a synchronous RAM plus the
// request sequencer that moves entries for insert and remove.
// Depends on iol_pkg.

// One request is worked at a time; the result appears in an output register
// so the next request is taken while the previous result waits. Append, clear
// and refused requests go straight to the response step; get and pop pass a
// fetch step first; remove fetches and then moves entries, insert moves them
// without a fetch. Moves are paced by the single word RAM, which moves one
// entry per cycle (read one ahead, write one behind). No clearing pass after
// reset: entries are only read below the length.
module indexed_ordered_list #(
	parameter int DEPTH     = iol_pkg::DEPTH_DEF,
	parameter int WORD_BITS = iol_pkg::WORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [iol_pkg::REQ_W-1:0]  req_type,
	input  logic [iol_pkg::POS_W-1:0]  position,
	input  logic [iol_pkg::DATA_W-1:0] word_in,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic [iol_pkg::DATA_W-1:0] word_out,
	output logic                       failed,
	output logic [iol_pkg::LEN_W-1:0]  length
);
	import iol_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_SHIFT = 4'b0100,
		ST_RESP  = 4'b1000
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        cnt_q;
	logic [REQ_W-1:0]     op_q;
	logic [AW-1:0]        pos_q;
	logic [WORD_BITS-1:0] word_q;
	logic [WORD_BITS-1:0] res_q;
	logic                 fail_q;
	logic [AW-1:0]        src_q;
	logic [CW-1:0]        rem_q;
	logic                 pend_s1;
	logic [AW-1:0]        dst_s1;
	logic                 res_valid_q;
	logic [DATA_W-1:0]    word_out_q;
	logic                 failed_q;
	logic [LEN_W-1:0]     length_q;

	logic [WORD_BITS-1:0] mem_q [DEPTH];
	logic [WORD_BITS-1:0] rd_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [AW-1:0]        mem_raddr;

	logic                 accept;
	logic                 bad;
	logic                 full;
	logic                 slot_free;
	logic                 is_remove;
	logic                 shift_done;
	logic [CMPW-1:0]      pos_x;
	logic [CMPW-1:0]      cnt_x;
	logic [CW-1:0]        pos_c;
	logic [CW-1:0]        cnt_m1;

	assign req_ready  = (state_q == ST_IDLE);
	assign accept     = req_valid && req_ready;
	assign full       = (cnt_q == CW'(DEPTH));
	assign pos_x      = CMPW'(position);
	assign cnt_x      = CMPW'(cnt_q);
	assign pos_c      = CW'(position);
	assign cnt_m1     = cnt_q - CW'(1);
	assign slot_free  = !res_valid_q || res_ready;
	assign is_remove  = (op_q == REQ_REMOVE);
	assign shift_done = (rem_q == '0) && !pend_s1;

	always_comb begin
		case (req_type)
			REQ_APPEND: bad = full;
			REQ_POP:    bad = (cnt_q == '0);
			REQ_GET:    bad = (pos_x >= cnt_x);
			REQ_REMOVE: bad = (pos_x >= cnt_x);
			REQ_INSERT: bad = full || (pos_x > cnt_x);
			REQ_CLEAR:  bad = 1'b0;
			default:    bad = 1'b1;
		endcase
	end

	// single write port: append at accept, moved entry, or the inserted word
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = WORD_BITS'(word_in);
		if (state_q == ST_IDLE) begin
			mem_we = accept && !bad && (req_type == REQ_APPEND);
		end else if (state_q == ST_SHIFT) begin
			if (pend_s1) begin
				mem_we    = 1'b1;
				mem_waddr = dst_s1;
				mem_wdata = rd_q;
			end else if (rem_q == '0 && op_q == REQ_INSERT) begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = word_q;
			end
		end
	end

	always_comb begin
		if (state_q == ST_IDLE) begin
			mem_raddr = (req_type == REQ_POP) ? cnt_m1[AW-1:0] : pos_x[AW-1:0];
		end else begin
			mem_raddr = src_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			op_q        <= '0;
			src_q       <= '0;
			rem_q       <= '0;
			pend_s1     <= 1'b0;
			fail_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESP && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q   <= req_type;
						fail_q <= bad;
						if (bad) begin
							state_q <= ST_RESP;
						end else begin
							case (req_type)
								REQ_APPEND: begin
									cnt_q   <= cnt_q + CW'(1);
									state_q <= ST_RESP;
								end
								REQ_POP: begin
									cnt_q   <= cnt_m1;
									state_q <= ST_FETCH;
								end
								REQ_GET, REQ_REMOVE: begin
									state_q <= ST_FETCH;
								end
								REQ_INSERT: begin
									// move entries pos..cnt-1 up by one, top first
									src_q   <= cnt_m1[AW-1:0];
									rem_q   <= cnt_q - pos_c;
									state_q <= ST_SHIFT;
								end
								REQ_CLEAR: begin
									cnt_q   <= '0;
									state_q <= ST_RESP;
								end
								default: begin
									state_q <= ST_RESP;
								end
							endcase
						end
					end
				end
				ST_FETCH: begin
					if (is_remove) begin
						// move entries pos+1..cnt-1 down by one, bottom first
						src_q   <= pos_q + AW'(1);
						rem_q   <= cnt_q - CW'(pos_q) - CW'(1);
						state_q <= ST_SHIFT;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_SHIFT: begin
					pend_s1 <= (rem_q != '0);
					if (rem_q != '0) begin
						src_q <= is_remove ? src_q + AW'(1) : src_q - AW'(1);
						rem_q <= rem_q - CW'(1);
					end else if (!pend_s1) begin
						cnt_q   <= is_remove ? cnt_m1 : cnt_q + CW'(1);
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q  <= pos_x[AW-1:0];
			word_q <= WORD_BITS'(word_in);
			res_q  <= '0;
		end
		if (state_q == ST_FETCH) begin
			res_q <= rd_q;
		end
		if (state_q == ST_SHIFT && rem_q != '0) begin
			dst_s1 <= is_remove ? src_q - AW'(1) : src_q + AW'(1);
		end
		if (state_q == ST_RESP && slot_free) begin
			word_out_q <= fail_q ? '0 : DATA_W'(res_q);
			failed_q   <= fail_q;
			length_q   <= LEN_W'(cnt_q);
		end
	end

	assign res_valid = res_valid_q;
	assign word_out  = word_out_q;
	assign failed    = failed_q;
	assign length    = length_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_pend_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == ST_SHIFT))
		else $error("moved entry pending outside shift");

	a_bad_code: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type > REQ_CLEAR) |=> (fail_q && state_q == ST_RESP))
		else $error("unused request code not refused");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && failed) |-> (word_out == '0))
		else $error("refused beat carries a word");

	a_rise_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == ST_RESP))
		else $error("result beat without a response step");

endmodule
